/* hw/rtl/lfm_pkg.sv */
// ----------------------------------------------------------------------------
// lfm_pkg
// shared codes of the line follower: line classes, led colors, actions,
// configuration register indexes
// ----------------------------------------------------------------------------
package lfm_pkg;

	localparam int unsigned SENSOR_W = 8;
	localparam int unsigned CLASS_W  = 4;
	localparam int unsigned STATE_W  = 4;
	localparam int unsigned LED_W    = 3;
	localparam int unsigned DUTY_W   = 16;
	localparam int unsigned ACT_W    = 3;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned NUM_REGS = 5;

	typedef logic [SENSOR_W-1:0] sensor_t;
	typedef logic [CLASS_W-1:0]  class_t;
	typedef logic [STATE_W-1:0]  state_code_t;
	typedef logic [LED_W-1:0]    led_t;
	typedef logic [DUTY_W-1:0]   duty_t;
	typedef logic [ACT_W-1:0]    act_t;

	// line classes, far left to far right
	localparam class_t CLS_LOST   = 4'd0;
	localparam class_t CLS_L4     = 4'd1;
	localparam class_t CLS_L3     = 4'd2;
	localparam class_t CLS_L2     = 4'd3;
	localparam class_t CLS_L1     = 4'd4;
	localparam class_t CLS_CENTER = 4'd5;
	localparam class_t CLS_R1     = 4'd6;
	localparam class_t CLS_R2     = 4'd7;
	localparam class_t CLS_R3     = 4'd8;
	localparam class_t CLS_R4     = 4'd9;

	// state numbers as seen on the result word
	localparam state_code_t SC_STRAIGHT = 4'd0;
	localparam state_code_t SC_BACKUP   = 4'd9;
	localparam state_code_t SC_STOP     = 4'd10;

	localparam led_t LED_CLEAR  = 3'd0;
	localparam led_t LED_RED    = 3'd1;
	localparam led_t LED_GREEN  = 3'd2;
	localparam led_t LED_YELLOW = 3'd3;
	localparam led_t LED_BLUE   = 3'd4;

	localparam act_t ACT_FORWARD = 3'd0;
	localparam act_t ACT_PIVOT_R = 3'd1;
	localparam act_t ACT_PIVOT_L = 3'd2;
	localparam act_t ACT_BACKUP  = 3'd3;
	localparam act_t ACT_STOP    = 3'd4;

	// configuration register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_FULL = 3'd0,
		REG_SOFT = 3'd1,
		REG_MID  = 3'd2,
		REG_HARD = 3'd3,
		REG_TURN = 3'd4
	} reg_idx_t;

	localparam duty_t RST_FULL = 16'd10000;
	localparam duty_t RST_SOFT = 16'd9900;
	localparam duty_t RST_MID  = 16'd9500;
	localparam duty_t RST_HARD = 16'd8000;
	localparam duty_t RST_TURN = 16'd6000;

endpackage

/* hw/rtl/lfm_if.sv */
// ----------------------------------------------------------------------------
// lfm_if
// valid/ready channels of the line follower: sensor words in, result words out
// ----------------------------------------------------------------------------
interface lfm_sens_if;
	logic              valid;
	logic              ready;
	lfm_pkg::sensor_t  sensor_bits;

	modport source (output valid, output sensor_bits, input ready);
	modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lfm_res_if;
	logic                  valid;
	logic                  ready;
	lfm_pkg::class_t       line_class;
	lfm_pkg::state_code_t  new_state;
	lfm_pkg::led_t         led_color;
	lfm_pkg::duty_t        left_duty;
	lfm_pkg::duty_t        right_duty;
	lfm_pkg::act_t         action;

	modport source (output valid, output line_class, output new_state, output led_color,
		output left_duty, output right_duty, output action, input ready);
	modport sink   (input valid, input line_class, input new_state, input led_color,
		input left_duty, input right_duty, input action, output ready);
endinterface

/* hw/rtl/line_follower_moore_fsm.sv */
// ----------------------------------------------------------------------------
// line_follower_moore_fsm
// classifies 8-bit reflectance patterns into a line class and steps an
// 11-state moore machine that drives led color, motor duties and action
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-----------------------------------------
//  sens    | in  | valid / ready      | sensor_bits
//  res     | out | valid / ready      | line_class, new_state, led_color,
//          |     |                    | left_duty, right_duty, action
//  apb     | in  | psel/penable/pwrite| 5 duty registers at byte 0x00..0x10
//
// one word per cycle sustained while res is not stalled; a word goes from sens
// accept through the input register, then classify + state step into the
// result register; the state step is one level of case logic in the state loop
// reset clears both pipeline valids, the state to straight, the last class to
// lost and the duty registers to their defaults
// a stalled res holds its word; the input register still takes a new word
// whenever the result register is free or being drained in the same cycle
//
module line_follower_moore_fsm (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lfm_pkg::ADDR_W-1:0]    paddr,
	input  logic [lfm_pkg::DATA_W-1:0]    pwdata,
	output logic [lfm_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// data channels
	lfm_sens_if.sink                      sens,
	lfm_res_if.source                     res
);

	// moore states, numbered in table order
	typedef enum logic [3:0] {
		ST_STRAIGHT = 4'd0,
		ST_SOFT_R   = 4'd1,
		ST_MID_R    = 4'd2,
		ST_HARD_R   = 4'd3,
		ST_TURN_R   = 4'd4,
		ST_SOFT_L   = 4'd5,
		ST_MID_L    = 4'd6,
		ST_HARD_L   = 4'd7,
		ST_TURN_L   = 4'd8,
		ST_BACKUP   = 4'd9,
		ST_STOP     = 4'd10
	} state_t;

	// which register feeds a wheel
	typedef enum logic [2:0] {
		DS_FULL,
		DS_SOFT,
		DS_MID,
		DS_HARD,
		DS_TURN,
		DS_ZERO
	} duty_sel_t;

	// ---------------- configuration registers ----------------
	lfm_pkg::duty_t full_q, soft_q, mid_q, hard_q, turn_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[lfm_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= lfm_pkg::RST_FULL;
			soft_q <= lfm_pkg::RST_SOFT;
			mid_q  <= lfm_pkg::RST_MID;
			hard_q <= lfm_pkg::RST_HARD;
			turn_q <= lfm_pkg::RST_TURN;
		end else if (wr_en) begin
			// writes beyond the last register are dropped
			case (reg_idx)
				lfm_pkg::REG_FULL: full_q <= pwdata[lfm_pkg::DUTY_W-1:0];
				lfm_pkg::REG_SOFT: soft_q <= pwdata[lfm_pkg::DUTY_W-1:0];
				lfm_pkg::REG_MID:  mid_q  <= pwdata[lfm_pkg::DUTY_W-1:0];
				lfm_pkg::REG_HARD: hard_q <= pwdata[lfm_pkg::DUTY_W-1:0];
				lfm_pkg::REG_TURN: turn_q <= pwdata[lfm_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			lfm_pkg::REG_FULL: prdata = {{(lfm_pkg::DATA_W-lfm_pkg::DUTY_W){1'b0}}, full_q};
			lfm_pkg::REG_SOFT: prdata = {{(lfm_pkg::DATA_W-lfm_pkg::DUTY_W){1'b0}}, soft_q};
			lfm_pkg::REG_MID:  prdata = {{(lfm_pkg::DATA_W-lfm_pkg::DUTY_W){1'b0}}, mid_q};
			lfm_pkg::REG_HARD: prdata = {{(lfm_pkg::DATA_W-lfm_pkg::DUTY_W){1'b0}}, hard_q};
			lfm_pkg::REG_TURN: prdata = {{(lfm_pkg::DATA_W-lfm_pkg::DUTY_W){1'b0}}, turn_q};
			default:           prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	logic             valid_s1;
	lfm_pkg::sensor_t sensor_s1;
	logic             advance;    // s1 word moves into the result register
	logic             res_free;

	assign res_free  = !res.valid || res.ready;
	assign advance   = valid_s1 && res_free;
	assign sens.ready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sens.ready) begin
			valid_s1 <= sens.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sens.ready && sens.valid) begin
			sensor_s1 <= sens.sensor_bits;
		end
	end

	// ---------------- classification ----------------
	state_t          state_q;
	lfm_pkg::class_t last_class_q;
	lfm_pkg::class_t cls;

	always_comb begin
		case (sensor_s1) inside
			8'h00:                             cls = lfm_pkg::CLS_LOST;
			8'h18, 8'h1C, 8'h38, 8'h3C:        cls = lfm_pkg::CLS_CENTER;
			8'h10, 8'h20, 8'h30:               cls = lfm_pkg::CLS_L1;
			8'h40, 8'h60, 8'h70, 8'hE0:        cls = lfm_pkg::CLS_L2;
			8'h80:                             cls = lfm_pkg::CLS_L3;
			8'h04, 8'h08, 8'h0C, 8'h01:        cls = lfm_pkg::CLS_R3;
			8'h02, 8'h03, 8'h06, 8'h07, 8'h0E: cls = lfm_pkg::CLS_R1;
			8'hF0, 8'hF8, 8'hFC, 8'hFE:        cls = lfm_pkg::CLS_L4;
			8'h0F, 8'h1F, 8'h3F, 8'h7F:        cls = lfm_pkg::CLS_R4;
			// unknown pattern keeps the previous class
			default:                           cls = last_class_q;
		endcase
	end

	// ---------------- next state ----------------
	state_t next_st;

	always_comb begin
		next_st = ST_STOP;
		if (state_q == ST_BACKUP) begin
			// backing up until the line shows again, then pivot toward it
			if (cls == lfm_pkg::CLS_LOST)        next_st = ST_BACKUP;
			else if (cls <= lfm_pkg::CLS_CENTER) next_st = ST_TURN_L;
			else                                 next_st = ST_TURN_R;
		end else if (cls == lfm_pkg::CLS_LOST) begin
			// lost after a hard move or a pivot: back up, otherwise halt
			if (state_q inside {ST_HARD_R, ST_TURN_R, ST_HARD_L, ST_TURN_L})
				next_st = ST_BACKUP;
			else
				next_st = ST_STOP;
		end else begin
			case (cls)
				lfm_pkg::CLS_L4:     next_st = ST_TURN_L;
				lfm_pkg::CLS_L3:     next_st = ST_HARD_L;
				lfm_pkg::CLS_L2:     next_st = ST_MID_L;
				lfm_pkg::CLS_L1:     next_st = ST_SOFT_L;
				lfm_pkg::CLS_CENTER: next_st = ST_STRAIGHT;
				lfm_pkg::CLS_R1:     next_st = ST_SOFT_R;
				lfm_pkg::CLS_R2:     next_st = ST_MID_R;
				lfm_pkg::CLS_R3:     next_st = ST_HARD_R;
				lfm_pkg::CLS_R4:     next_st = ST_TURN_R;
				default:             next_st = ST_STOP;
			endcase
		end
	end

	// ---------------- moore outputs of the next state ----------------
	lfm_pkg::led_t  nxt_led;
	lfm_pkg::act_t  nxt_act;
	duty_sel_t      lsel, rsel;
	lfm_pkg::duty_t nxt_left, nxt_right;

	always_comb begin
		case (next_st)
			ST_STRAIGHT: begin
				nxt_led = lfm_pkg::LED_CLEAR;  nxt_act = lfm_pkg::ACT_FORWARD;
				lsel = DS_FULL; rsel = DS_FULL;
			end
			ST_SOFT_R: begin
				nxt_led = lfm_pkg::LED_BLUE;   nxt_act = lfm_pkg::ACT_FORWARD;
				lsel = DS_FULL; rsel = DS_SOFT;
			end
			ST_MID_R: begin
				nxt_led = lfm_pkg::LED_YELLOW; nxt_act = lfm_pkg::ACT_FORWARD;
				lsel = DS_FULL; rsel = DS_MID;
			end
			ST_HARD_R: begin
				nxt_led = lfm_pkg::LED_GREEN;  nxt_act = lfm_pkg::ACT_FORWARD;
				lsel = DS_FULL; rsel = DS_HARD;
			end
			ST_TURN_R: begin
				nxt_led = lfm_pkg::LED_RED;    nxt_act = lfm_pkg::ACT_PIVOT_R;
				lsel = DS_TURN; rsel = DS_TURN;
			end
			ST_SOFT_L: begin
				nxt_led = lfm_pkg::LED_BLUE;   nxt_act = lfm_pkg::ACT_FORWARD;
				lsel = DS_SOFT; rsel = DS_FULL;
			end
			ST_MID_L: begin
				nxt_led = lfm_pkg::LED_YELLOW; nxt_act = lfm_pkg::ACT_FORWARD;
				lsel = DS_MID;  rsel = DS_FULL;
			end
			ST_HARD_L: begin
				nxt_led = lfm_pkg::LED_GREEN;  nxt_act = lfm_pkg::ACT_FORWARD;
				lsel = DS_HARD; rsel = DS_FULL;
			end
			ST_TURN_L: begin
				nxt_led = lfm_pkg::LED_RED;    nxt_act = lfm_pkg::ACT_PIVOT_L;
				lsel = DS_TURN; rsel = DS_TURN;
			end
			ST_BACKUP: begin
				nxt_led = lfm_pkg::LED_CLEAR;  nxt_act = lfm_pkg::ACT_BACKUP;
				lsel = DS_TURN; rsel = DS_TURN;
			end
			// stop, and any code outside the table
			default: begin
				nxt_led = lfm_pkg::LED_CLEAR;  nxt_act = lfm_pkg::ACT_STOP;
				lsel = DS_ZERO; rsel = DS_ZERO;
			end
		endcase
	end

	function automatic lfm_pkg::duty_t pick_duty(
		input duty_sel_t sel, input lfm_pkg::duty_t f, input lfm_pkg::duty_t s,
		input lfm_pkg::duty_t m, input lfm_pkg::duty_t h, input lfm_pkg::duty_t t);
		case (sel)
			DS_FULL: return f;
			DS_SOFT: return s;
			DS_MID:  return m;
			DS_HARD: return h;
			DS_TURN: return t;
			default: return '0;
		endcase
	endfunction

	assign nxt_left  = pick_duty(lsel, full_q, soft_q, mid_q, hard_q, turn_q);
	assign nxt_right = pick_duty(rsel, full_q, soft_q, mid_q, hard_q, turn_q);

	// ---------------- state and result register ----------------
	lfm_pkg::class_t res_class_q;
	lfm_pkg::led_t   res_led_q;
	lfm_pkg::act_t   res_act_q;
	lfm_pkg::duty_t  res_left_q, res_right_q;
	logic            res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_STRAIGHT;
			last_class_q <= lfm_pkg::CLS_LOST;
			res_valid_q  <= 1'b0;
			res_class_q  <= lfm_pkg::CLS_LOST;
			res_led_q    <= lfm_pkg::LED_CLEAR;
			res_act_q    <= lfm_pkg::ACT_FORWARD;
			res_left_q   <= '0;
			res_right_q  <= '0;
		end else begin
			if (res_free) begin
				res_valid_q <= valid_s1;
			end
			if (advance) begin
				state_q      <= next_st;
				last_class_q <= cls;
				res_class_q  <= cls;
				res_led_q    <= nxt_led;
				res_act_q    <= nxt_act;
				res_left_q   <= nxt_left;
				res_right_q  <= nxt_right;
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.line_class = res_class_q;
	assign res.new_state  = state_q;
	assign res.led_color  = res_led_q;
	assign res.left_duty  = res_left_q;
	assign res.right_duty = res_right_q;
	assign res.action     = res_act_q;

endmodule

/* hw/rtl/lfm_chk.sv */
// ----------------------------------------------------------------------------
// lfm_chk
// port-level checks of the line follower result channel
// ----------------------------------------------------------------------------
module lfm_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  res_valid,
	input logic                  res_ready,
	input lfm_pkg::class_t       line_class,
	input lfm_pkg::state_code_t  new_state,
	input lfm_pkg::led_t         led_color,
	input lfm_pkg::duty_t        left_duty,
	input lfm_pkg::duty_t        right_duty,
	input lfm_pkg::act_t         action
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(new_state) && $stable(left_duty)
			&& $stable(right_duty) && $stable(line_class))
		else $error("result word changed while stalled");

	// stop drives both wheels at zero with the stop action
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && new_state == lfm_pkg::SC_STOP |->
			left_duty == '0 && right_duty == '0 && action == lfm_pkg::ACT_STOP)
		else $error("stop state with nonzero duty");

	// straight runs both wheels on the same register
	a_straight: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && new_state == lfm_pkg::SC_STRAIGHT |->
			left_duty == right_duty && action == lfm_pkg::ACT_FORWARD
			&& led_color == lfm_pkg::LED_CLEAR)
		else $error("straight state with unequal duties");

	// a lost line ends in backup or stop
	a_lost: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && line_class == lfm_pkg::CLS_LOST |->
			new_state == lfm_pkg::SC_BACKUP || new_state == lfm_pkg::SC_STOP)
		else $error("lost line did not lead to backup or stop");

endmodule

bind line_follower_moore_fsm lfm_chk u_lfm_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.line_class (res.line_class),
	.new_state  (res.new_state),
	.led_color  (res.led_color),
	.left_duty  (res.left_duty),
	.right_duty (res.right_duty),
	.action     (res.action)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the line follower moore machine: sensor words go in
// through a valid/ready channel, every result word is checked field by field
// against a predictor of the classifier and state table kept in the bench;
// duty registers are written and read back over the apb port between phases
// ----------------------------------------------------------------------------
module tb_top;

	// state numbers that the package leaves unnamed
	localparam lfm_pkg::state_code_t ST_STRAIGHT = lfm_pkg::SC_STRAIGHT;
	localparam lfm_pkg::state_code_t ST_SOFT_R   = 4'd1;
	localparam lfm_pkg::state_code_t ST_MID_R    = 4'd2;
	localparam lfm_pkg::state_code_t ST_HARD_R   = 4'd3;
	localparam lfm_pkg::state_code_t ST_TURN_R   = 4'd4;
	localparam lfm_pkg::state_code_t ST_SOFT_L   = 4'd5;
	localparam lfm_pkg::state_code_t ST_MID_L    = 4'd6;
	localparam lfm_pkg::state_code_t ST_HARD_L   = 4'd7;
	localparam lfm_pkg::state_code_t ST_TURN_L   = 4'd8;

	localparam int STALL_LIMIT  = 3000;  // cycles with no word moving on either channel
	localparam int IDLE_PERCENT = 17;
	localparam int DRAIN_CYCLES = 4;     // input and result registers plus margin
	localparam int NUM_ADDR     = 8;     // paddr reaches eight word slots

	// one result word as the block should produce it
	typedef struct packed {
		lfm_pkg::class_t      line_class;
		lfm_pkg::state_code_t new_state;
		lfm_pkg::led_t        led_color;
		lfm_pkg::duty_t       left_duty;
		lfm_pkg::duty_t       right_duty;
		lfm_pkg::act_t        action;
	} steer_word_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [lfm_pkg::ADDR_W-1:0] paddr;
	logic [lfm_pkg::DATA_W-1:0] pwdata;
	logic [lfm_pkg::DATA_W-1:0] prdata;
	logic pready;

	lfm_sens_if sens_ch ();
	lfm_res_if  res_ch ();

	line_follower_moore_fsm dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sens    (sens_ch),
		.res     (res_ch)
	);

	// bench copy of the block's state and duty registers
	lfm_pkg::state_code_t  mdl_state;
	lfm_pkg::class_t       mdl_class;
	lfm_pkg::duty_t        duty_reg [lfm_pkg::NUM_REGS];

	steer_word_t  pending_steer [$];

	int  fail_count;
	int  words_sent;
	int  words_checked;
	int  reg_writes;
	int  stall_cycles;
	int  hold_left;      // receiver hold-off, counted down by the receiver
	bit  calm;           // no idling on either side while set
	bit  [15:0] states_seen;

	// every pattern the classifier knows, the rest keep the last class
	lfm_pkg::sensor_t known_pats [30] = '{
		8'h00, 8'h18, 8'h1C, 8'h38, 8'h3C, 8'h10, 8'h20, 8'h30,
		8'h40, 8'h60, 8'h70, 8'hE0, 8'h80, 8'h04, 8'h08, 8'h0C,
		8'h01, 8'h02, 8'h03, 8'h06, 8'h07, 8'h0E, 8'hF0, 8'hF8,
		8'hFC, 8'hFE, 8'h0F, 8'h1F, 8'h3F, 8'h7F
	};

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// exact pattern match; anything unknown holds the previous class
	function automatic lfm_pkg::class_t sort_pattern(lfm_pkg::sensor_t pat,
			lfm_pkg::class_t prev);
		case (pat)
			8'h00:                             return lfm_pkg::CLS_LOST;
			8'h18, 8'h1C, 8'h38, 8'h3C:        return lfm_pkg::CLS_CENTER;
			8'h10, 8'h20, 8'h30:               return lfm_pkg::CLS_L1;
			8'h40, 8'h60, 8'h70, 8'hE0:        return lfm_pkg::CLS_L2;
			8'h80:                             return lfm_pkg::CLS_L3;
			8'h04, 8'h08, 8'h0C, 8'h01:        return lfm_pkg::CLS_R3;
			8'h02, 8'h03, 8'h06, 8'h07, 8'h0E: return lfm_pkg::CLS_R1;
			8'hF0, 8'hF8, 8'hFC, 8'hFE:        return lfm_pkg::CLS_L4;
			8'h0F, 8'h1F, 8'h3F, 8'h7F:        return lfm_pkg::CLS_R4;
			default:                           return prev;
		endcase
	endfunction

	function automatic lfm_pkg::state_code_t next_steer_state(lfm_pkg::state_code_t cur,
			lfm_pkg::class_t cls);
		// backup waits for the line, then pivots toward the side it shows up on
		if (cur == lfm_pkg::SC_BACKUP) begin
			if (cls == lfm_pkg::CLS_LOST)
				return lfm_pkg::SC_BACKUP;
			return (cls <= lfm_pkg::CLS_CENTER) ? ST_TURN_L : ST_TURN_R;
		end
		// line lost: back up out of hard corners and pivots, otherwise stop
		if (cls == lfm_pkg::CLS_LOST) begin
			if (cur == ST_HARD_R || cur == ST_TURN_R || cur == ST_HARD_L || cur == ST_TURN_L)
				return lfm_pkg::SC_BACKUP;
			return lfm_pkg::SC_STOP;
		end
		case (cls)
			lfm_pkg::CLS_L4:     return ST_TURN_L;
			lfm_pkg::CLS_L3:     return ST_HARD_L;
			lfm_pkg::CLS_L2:     return ST_MID_L;
			lfm_pkg::CLS_L1:     return ST_SOFT_L;
			lfm_pkg::CLS_CENTER: return ST_STRAIGHT;
			lfm_pkg::CLS_R1:     return ST_SOFT_R;
			lfm_pkg::CLS_R2:     return ST_MID_R;
			lfm_pkg::CLS_R3:     return ST_HARD_R;
			default:             return ST_TURN_R;
		endcase
	endfunction

	// one sensor word through classifier and state table, updating bench state
	function automatic steer_word_t step_steering(lfm_pkg::sensor_t pat);
		steer_word_t w;
		w.line_class = sort_pattern(pat, mdl_class);
		w.new_state  = next_steer_state(mdl_state, w.line_class);
		mdl_class    = w.line_class;
		mdl_state    = w.new_state;
		case (w.new_state)
			ST_STRAIGHT: w = '{w.line_class, w.new_state, lfm_pkg::LED_CLEAR,
				duty_reg[lfm_pkg::REG_FULL], duty_reg[lfm_pkg::REG_FULL],
				lfm_pkg::ACT_FORWARD};
			ST_SOFT_R: w = '{w.line_class, w.new_state, lfm_pkg::LED_BLUE,
				duty_reg[lfm_pkg::REG_FULL], duty_reg[lfm_pkg::REG_SOFT],
				lfm_pkg::ACT_FORWARD};
			ST_MID_R: w = '{w.line_class, w.new_state, lfm_pkg::LED_YELLOW,
				duty_reg[lfm_pkg::REG_FULL], duty_reg[lfm_pkg::REG_MID],
				lfm_pkg::ACT_FORWARD};
			ST_HARD_R: w = '{w.line_class, w.new_state, lfm_pkg::LED_GREEN,
				duty_reg[lfm_pkg::REG_FULL], duty_reg[lfm_pkg::REG_HARD],
				lfm_pkg::ACT_FORWARD};
			ST_TURN_R: w = '{w.line_class, w.new_state, lfm_pkg::LED_RED,
				duty_reg[lfm_pkg::REG_TURN], duty_reg[lfm_pkg::REG_TURN],
				lfm_pkg::ACT_PIVOT_R};
			ST_SOFT_L: w = '{w.line_class, w.new_state, lfm_pkg::LED_BLUE,
				duty_reg[lfm_pkg::REG_SOFT], duty_reg[lfm_pkg::REG_FULL],
				lfm_pkg::ACT_FORWARD};
			ST_MID_L: w = '{w.line_class, w.new_state, lfm_pkg::LED_YELLOW,
				duty_reg[lfm_pkg::REG_MID], duty_reg[lfm_pkg::REG_FULL],
				lfm_pkg::ACT_FORWARD};
			ST_HARD_L: w = '{w.line_class, w.new_state, lfm_pkg::LED_GREEN,
				duty_reg[lfm_pkg::REG_HARD], duty_reg[lfm_pkg::REG_FULL],
				lfm_pkg::ACT_FORWARD};
			ST_TURN_L: w = '{w.line_class, w.new_state, lfm_pkg::LED_RED,
				duty_reg[lfm_pkg::REG_TURN], duty_reg[lfm_pkg::REG_TURN],
				lfm_pkg::ACT_PIVOT_L};
			lfm_pkg::SC_BACKUP: w = '{w.line_class, w.new_state, lfm_pkg::LED_CLEAR,
				duty_reg[lfm_pkg::REG_TURN], duty_reg[lfm_pkg::REG_TURN],
				lfm_pkg::ACT_BACKUP};
			// stop: both wheels off
			default: w = '{w.line_class, w.new_state, lfm_pkg::LED_CLEAR, 16'd0, 16'd0,
				lfm_pkg::ACT_STOP};
		endcase
		return w;
	endfunction

	// ------------------------------------------------------------------
	// clock, reporting, watchdog
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("MISMATCH %s: got %0d expected %0d (word %0d)", what, got, want, words_checked);
	endtask

	// no word moving for too long means the block hung
	always @(posedge clk) begin
		if ((sens_ch.valid && sens_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles, %0d words pending",
				stall_cycles, pending_steer.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// result side: ready driver and checker
	// ------------------------------------------------------------------

	// ready drops at random, or stays low through a requested hold-off
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// each accepted result against the oldest pending prediction
	always @(posedge clk) begin
		steer_word_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_steer.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = pending_steer.pop_front();
				if (res_ch.line_class !== want.line_class)
					report_mismatch("line_class", res_ch.line_class, want.line_class);
				if (res_ch.new_state !== want.new_state)
					report_mismatch("new_state", res_ch.new_state, want.new_state);
				if (res_ch.led_color !== want.led_color)
					report_mismatch("led_color", res_ch.led_color, want.led_color);
				if (res_ch.left_duty !== want.left_duty)
					report_mismatch("left_duty", res_ch.left_duty, want.left_duty);
				if (res_ch.right_duty !== want.right_duty)
					report_mismatch("right_duty", res_ch.right_duty, want.right_duty);
				if (res_ch.action !== want.action)
					report_mismatch("action", res_ch.action, want.action);
				states_seen[want.new_state] = 1'b1;
			end
			words_checked++;
		end
	end

	// ------------------------------------------------------------------
	// sensor side and apb helpers
	// ------------------------------------------------------------------

	// random idle cycles first (with junk on the bus), then hold the word until taken
	task automatic send_sensor(input lfm_pkg::sensor_t pat);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			@(negedge clk);
			sens_ch.valid       <= 1'b0;
			sens_ch.sensor_bits <= lfm_pkg::sensor_t'($urandom);
		end
		@(negedge clk);
		sens_ch.valid       <= 1'b1;
		sens_ch.sensor_bits <= pat;
		do @(posedge clk); while (!sens_ch.ready);
		pending_steer.push_back(step_steering(pat));
		words_sent++;
	endtask

	// stop offering and let every pending result come out of the pipeline
	task automatic drain_results();
		@(negedge clk);
		sens_ch.valid <= 1'b0;
		while (pending_steer.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly known patterns and lost-line words, the rest any byte
	function automatic lfm_pkg::sensor_t pick_pattern();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return known_pats[$urandom_range(0, 29)];
		if (r < 75)
			return 8'h00;
		return lfm_pkg::sensor_t'($urandom);
	endfunction

	function automatic lfm_pkg::duty_t pick_duty();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 16'd0;
		if (r < 4)
			return 16'hFFFF;
		return lfm_pkg::duty_t'($urandom);
	endfunction

	// setup then access phase; slots past the last register are ignored by the block
	task automatic apb_write(input int unsigned slot, input lfm_pkg::duty_t val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lfm_pkg::ADDR_W'(slot * 4);
		pwdata  <= {16'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (slot < lfm_pkg::NUM_REGS)
			duty_reg[slot] = val;
		reg_writes++;
	endtask

	task automatic apb_check(input lfm_pkg::reg_idx_t idx);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= lfm_pkg::ADDR_W'(idx * 4);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'd0, duty_reg[idx]})
			report_mismatch("register readback", prdata, duty_reg[idx]);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_duties(input lfm_pkg::duty_t f, input lfm_pkg::duty_t s,
			input lfm_pkg::duty_t m, input lfm_pkg::duty_t h, input lfm_pkg::duty_t t);
		apb_write(lfm_pkg::REG_FULL, f);
		apb_write(lfm_pkg::REG_SOFT, s);
		apb_write(lfm_pkg::REG_MID, m);
		apb_write(lfm_pkg::REG_HARD, h);
		apb_write(lfm_pkg::REG_TURN, t);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_sensor(pick_pattern());
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// walk the table with reset duties: every class the classifier produces, backup in and out,
	// stop with zero duty, unknown patterns holding the class, both byte extremes
	task automatic test_table_walk();
		lfm_pkg::sensor_t walk [$];
		walk = '{8'h3C, 8'h1F, 8'h00, 8'h00, 8'h20, 8'h00, 8'h07, 8'hFE,
			8'h80, 8'h60, 8'h10, 8'h00, 8'h55, 8'h0C, 8'h00, 8'hF8,
			8'hAA, 8'h0E, 8'hFF, 8'h18, 8'h7F, 8'h00, 8'h00};
		foreach (walk[i])
			send_sensor(walk[i]);
		drain_results();
	endtask

	// every register written and read back; unmapped slots must not disturb them
	task automatic test_register_access();
		load_duties(16'd1234, 16'd2345, 16'd3456, 16'd4567, 16'd5678);
		for (int unsigned slot = lfm_pkg::NUM_REGS; slot < NUM_ADDR; slot++)
			apb_write(slot, 16'hFFFF);
		apb_check(lfm_pkg::REG_FULL);
		apb_check(lfm_pkg::REG_SOFT);
		apb_check(lfm_pkg::REG_MID);
		apb_check(lfm_pkg::REG_HARD);
		apb_check(lfm_pkg::REG_TURN);
		send_random(60);
		drain_results();
	endtask

	// all duties at zero, at full scale, then alternating
	task automatic test_duty_extremes();
		load_duties(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_random(80);
		drain_results();
		load_duties(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_random(80);
		drain_results();
		load_duties(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
		send_random(80);
		drain_results();
	endtask

	// bulk traffic over random settings; one round runs with no idling at all
	task automatic test_random_traffic();
		for (int round = 0; round < 4; round++) begin
			load_duties(pick_duty(), pick_duty(), pick_duty(), pick_duty(), pick_duty());
			calm = (round == 1);
			send_random(275);
			drain_results();
			calm = 1'b0;
		end
	endtask

	// receiver holds off long enough that the pipeline fills and stalls the input
	task automatic test_output_backpressure();
		hold_left = 300;
		send_random(80);
		drain_results();
	endtask

	// short bursts, each one fully drained before the next starts
	task automatic test_sender_pause();
		repeat (4) begin
			send_random(25);
			drain_results();
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		sens_ch.valid       = 1'b0;
		sens_ch.sensor_bits = '0;
		calm                = 1'b0;
		hold_left           = 0;
		fail_count          = 0;
		words_sent          = 0;
		words_checked       = 0;
		reg_writes          = 0;
		stall_cycles        = 0;
		states_seen         = '0;
		mdl_state           = lfm_pkg::SC_STRAIGHT;
		mdl_class           = lfm_pkg::CLS_LOST;
		duty_reg[lfm_pkg::REG_FULL] = lfm_pkg::RST_FULL;
		duty_reg[lfm_pkg::REG_SOFT] = lfm_pkg::RST_SOFT;
		duty_reg[lfm_pkg::REG_MID]  = lfm_pkg::RST_MID;
		duty_reg[lfm_pkg::REG_HARD] = lfm_pkg::RST_HARD;
		duty_reg[lfm_pkg::REG_TURN] = lfm_pkg::RST_TURN;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_table_walk();
		test_register_access();
		test_duty_extremes();
		test_random_traffic();
		test_output_backpressure();
		test_sender_pause();

		if (pending_steer.size() != 0)
			report_mismatch("results never delivered", 0, pending_steer.size());

		$display("covered %0d sensor words, %0d results, %0d register writes",
			words_sent, words_checked, reg_writes);
		$display("states reached (bit per state): %b", states_seen[10:0]);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/lfm_pkg.sv
hw/rtl/lfm_if.sv
hw/rtl/line_follower_moore_fsm.sv
hw/rtl/lfm_chk.sv
tb/tb_top.sv
